>>> rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// types, character codes and hex helpers shared by the url percent decoder
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int UPD_QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   localparam logic [7:0] DIGIT_OFFSET = 8'd48;
   localparam logic [7:0] UPPER_OFFSET = 8'd55;
   localparam logic [7:0] LOWER_OFFSET = 8'd87;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } rsp_type;

   // one accepted item's results, waiting between front and back
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            fin;
   } work_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_F);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c - DIGIT_OFFSET;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         v = c - UPPER_OFFSET;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         v = c - LOWER_OFFSET;
      end else begin
         v = 8'd0;
      end
      return v[3:0];
   endfunction

endpackage

>>> rtl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front
// escape tracking and classification of each input byte into 0..3 results
// ----------------------------------------------------------------------------
module upd_front
   import upd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req_data,
   output logic     work_push,
   output work_type work_data
);

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_comb begin
      logic [7:0]      c;
      logic            plain;
      logic [1:0]      n;
      logic [2:0][7:0] b;
      phase_type       ph;
      logic [7:0]      hd;
      c     = req_data.in_byte;
      plain = 1'b0;
      n     = 2'd0;
      b     = '0;
      ph    = PH_IDLE;
      hd    = 8'd0;

      unique case (phase_ff)
         PH_PCT: begin
            if (is_hex(c)) begin
               ph = PH_DIGIT;
               hd = c;
            end else begin
               b[0]  = CH_PERCENT;
               n     = 2'd1;
               plain = 1'b1;
            end
         end
         PH_DIGIT: begin
            if (is_hex(c)) begin
               b[0] = {hex_value(held_ff), hex_value(c)};
               n    = 2'd1;
            end else begin
               b[0]  = CH_PERCENT;
               b[1]  = held_ff;
               n     = 2'd2;
               plain = 1'b1;
            end
         end
         default: begin
            plain = 1'b1;
         end
      endcase

      if (plain) begin
         if (c == CH_PLUS) begin
            b[n] = CH_SPACE;
            n    = n + 2'd1;
         end else if (c == CH_PERCENT) begin
            ph = PH_PCT;
            hd = 8'd0;
         end else begin
            b[n] = c;
            n    = n + 2'd1;
         end
      end

      // end of string flushes whatever escape is still pending
      if (req_data.is_final) begin
         if (ph == PH_PCT) begin
            b[n] = CH_PERCENT;
            n    = n + 2'd1;
         end else if (ph == PH_DIGIT) begin
            b[n]        = CH_PERCENT;
            b[n + 2'd1] = hd;
            n           = n + 2'd2;
         end
         ph = PH_IDLE;
         hd = 8'd0;
      end

      phase_in        = ph;
      held_in         = hd;
      work_data.bytes = b;
      work_data.count = n;
      work_data.fin   = req_data.is_final;
      work_push       = accept && (n != 2'd0);
   end

endmodule

>>> rtl/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue
// small register queue of work entries between front and back
// ----------------------------------------------------------------------------
module upd_queue
   import upd_pkg::*;
#(
   parameter int DEPTH = UPD_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  work_type     push_data,
   input  logic         pop,
   output work_type     head,
   output q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   work_type         entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.valid = (count_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back
// splits each work entry into beats and holds the result output register
// ----------------------------------------------------------------------------
module upd_back
   import upd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  work_type     head,
   input  q_status_type q_status,
   output logic         q_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output rsp_type      rsp_data
);

   logic [1:0] beat_ff, beat_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;
   logic       load, last;

   assign last  = (beat_ff == head.count - 2'd1);
   assign load  = q_status.valid && (!valid_ff || rsp_pop);
   assign q_pop = load && last;

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in           = 1'b1;
         data_in.out_byte   = head.bytes[beat_ff];
         data_in.run_end    = last;
         data_in.string_end = last && head.fin;
         beat_in            = last ? 2'd0 : beat_ff + 2'd1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> rtl/url_percent_decoder_unit.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// streaming url form decoder: '+' to space, %hh to one byte, broken escapes
// passed through as literals, pending escape flushed at end of string
// ----------------------------------------------------------------------------
//  channel | ports                        | beat
//  --------+------------------------------+------------------------------------
//  req     | req_push, req_full, req_data | one encoded byte plus end mark
//  rsp     | rsp_pop, rsp_empty, rsp_data | one decoded byte plus end flags
//
//  one input beat is taken per cycle while the work queue has room; the front
//  classifies it in the same cycle into 0..3 result bytes, written as one entry if any
//  the back drains entries at one result beat per cycle while the output
//  register is free or being popped; an item's results pass through a queue
//  entry and then the output register on their way to rsp_data
//  synchronous reset clears the escape phase, the queue and the output
//  register; rsp stalls back up into the queue and only then raise req_full
// ----------------------------------------------------------------------------
module url_percent_decoder_unit
   import upd_pkg::*;
#(
   parameter int QUEUE_DEPTH = UPD_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data
);

   q_status_type q_status;
   work_type     work_data;
   work_type     head;
   logic         work_push;
   logic         q_pop;
   logic         accept;

   // full is purely the queue state, never a function of rsp_pop
   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   // front: escape state machine, turns one byte into at most one work entry
   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .work_push (work_push),
      .work_data (work_data)
   );

   // queue decouples classification from the serializing back end
   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_data),
      .pop       (q_pop),
      .head      (head),
      .status    (q_status)
   );

   // back: one result beat per cycle into the output register while it is free or being popped
   upd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   // a full queue always has an entry to drain
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> q_status.valid)
      else $error("queue full without a valid head");

   // end of string is only flagged on the last beat of an item
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.string_end) |-> rsp_data.run_end)
      else $error("string_end without run_end");

   // output register comes out of reset empty
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending right after reset");

   // the back only pops an entry when it is moving a beat out
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.valid && (rsp_empty || rsp_pop))
      else $error("queue popped without a beat leaving");

endmodule
